FILE: sv/pdc_pkg.sv
package pdc_pkg;

   // Field widths
   localparam int TEMP_W  = 8;
   localparam int GAIN_W  = 16;
   localparam int ERR_W   = 9;
   localparam int PRIOR_W = 10;
   localparam int DIFF_W  = 10;
   localparam int SUM_W   = 24;
   localparam int DUTY_W  = 7;
   localparam int STAT_W  = 2;

   // Product and accumulator widths (units of 1/512)
   localparam int PTERM_W = GAIN_W + ERR_W + 1;
   localparam int ITERM_W = GAIN_W + SUM_W;
   localparam int DTERM_W = GAIN_W + DIFF_W + 2;
   localparam int ACC_W   = ITERM_W + 2;
   localparam int FRAC_W  = 9;

   // Duty and status codes
   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
   localparam logic [STAT_W-1:0] ST_OFF     = 2'd0;
   localparam logic [STAT_W-1:0] ST_HEATING = 2'd1;
   localparam logic [STAT_W-1:0] ST_COOLING = 2'd2;
   localparam logic [STAT_W-1:0] ST_STABLE  = 2'd3;
   localparam logic signed [ERR_W-1:0] STABLE_BAND = 9'sd2;

   // Register map (word index)
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
   localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
   localparam logic [1:0] REG_DERIV_GAIN = 2'd2;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop;
      logic signed [GAIN_W-1:0] integ;
      logic signed [GAIN_W-1:0] deriv;
   } pdc_gains_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [ERR_W-1:0]  err;
      logic signed [SUM_W-1:0]  sum;
      logic signed [DIFF_W-1:0] diff;
   } pdc_err_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [PTERM_W-1:0] p_term;
      logic signed [ITERM_W-1:0] i_term;
      logic signed [DTERM_W-1:0] d_term;
   } pdc_prod_type;

endpackage

FILE: sv/pdc_csr.sv
module pdc_csr
   import pdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output pdc_gains_type         gains
);

   pdc_gains_type gains_ff;
   logic          wr_en;
   logic [1:0]    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign gains      = gains_ff;

   // Write the addressed gain; drop writes beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= PROP_GAIN_RST;
         gains_ff.integ <= INTEG_GAIN_RST;
         gains_ff.deriv <= DERIV_GAIN_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PROP_GAIN:  gains_ff.prop  <= csr_pwdata[GAIN_W-1:0];
            REG_INTEG_GAIN: gains_ff.integ <= csr_pwdata[GAIN_W-1:0];
            REG_DERIV_GAIN: gains_ff.deriv <= csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back, sign extended
   always_comb begin
      unique case (reg_idx)
         REG_PROP_GAIN:  csr_prdata = {{(32-GAIN_W){gains_ff.prop[GAIN_W-1]}}, gains_ff.prop};
         REG_INTEG_GAIN: csr_prdata = {{(32-GAIN_W){gains_ff.integ[GAIN_W-1]}}, gains_ff.integ};
         REG_DERIV_GAIN: csr_prdata = {{(32-GAIN_W){gains_ff.deriv[GAIN_W-1]}}, gains_ff.deriv};
         default:        csr_prdata = 32'd0;
      endcase
   end

endmodule

FILE: sv/pdc_error.sv
module pdc_error
   import pdc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     system_on,
   input  logic signed [TEMP_W-1:0] measured_temp,
   input  logic signed [TEMP_W-1:0] target_temp,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pdc_err_type              out_data
);

   logic                        valid_ff;
   pdc_err_type                 data_ff;
   pdc_err_type                 data_in;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [SUM_W-1:0]     sum_in;
   logic signed [PRIOR_W-1:0]   prior_ff;
   logic signed [ERR_W-1:0]     err;
   logic signed [SUM_W:0]       sum_wide;
   logic signed [SUM_W-1:0]     sum_sat;
   logic signed [DIFF_W-1:0]    diff;
   logic [STAT_W-1:0]           status;
   logic                        take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Error and saturating error sum
   assign err      = {target_temp[TEMP_W-1], target_temp}
                   - {measured_temp[TEMP_W-1], measured_temp};
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff}
                   + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
   always_comb begin
      case (sum_wide[SUM_W:SUM_W-1])
         2'b01:   sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
         2'b10:   sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
         default: sum_sat = sum_wide[SUM_W-1:0];
      endcase
   end
   assign sum_in = system_on ? sum_sat : '0;

   // Difference against the previous running error
   assign diff = {{(DIFF_W-ERR_W){err[ERR_W-1]}}, err} - prior_ff;

   // Band status
   always_comb begin
      if (!system_on)
         status = ST_OFF;
      else if (err > STABLE_BAND)
         status = ST_HEATING;
      else if (err < -STABLE_BAND)
         status = ST_COOLING;
      else
         status = ST_STABLE;
   end

   always_comb begin
      data_in.status = status;
      data_in.err    = err;
      data_in.sum    = sum_sat;
      data_in.diff   = diff;
   end

   // Advance controller state as each word enters
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff   <= '0;
         prior_ff <= '0;
      end else begin
         if (in_ready)
            valid_ff <= in_valid;
         if (take) begin
            sum_ff   <= sum_in;
            prior_ff <= system_on ? {{(PRIOR_W-ERR_W){err[ERR_W-1]}}, err} : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take)
         data_ff <= data_in;
   end

endmodule

FILE: sv/pdc_product.sv
module pdc_product
   import pdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pdc_gains_type gains,
   input  logic          in_valid,
   output logic          in_ready,
   input  pdc_err_type   in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output pdc_prod_type  out_data
);

   logic                        valid_ff;
   pdc_prod_type                data_ff;
   pdc_prod_type                data_in;
   logic signed [PTERM_W-2:0]   p_raw;
   logic signed [ITERM_W-1:0]   i_raw;
   logic signed [DTERM_W-3:0]   d_raw;
   logic                        take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Three gain products, scaled to 1/512 units
   assign p_raw = gains.prop  * in_data.err;
   assign i_raw = gains.integ * in_data.sum;
   assign d_raw = gains.deriv * in_data.diff;

   always_comb begin
      data_in.status = in_data.status;
      data_in.p_term = {p_raw, 1'b0};
      data_in.i_term = i_raw;
      data_in.d_term = {d_raw, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (in_ready)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (take)
         data_ff <= data_in;
   end

endmodule

FILE: sv/pdc_output.sv
module pdc_output
   import pdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pdc_prod_type      in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DUTY_W-1:0] duty_cycle,
   output logic [STAT_W-1:0] heat_status
);

   logic                      valid_ff;
   logic [DUTY_W-1:0]         duty_ff;
   logic [DUTY_W-1:0]         duty_in;
   logic [STAT_W-1:0]         status_ff;
   logic signed [ACC_W-1:0]   acc;
   logic [ACC_W-FRAC_W-1:0]   whole;
   logic [DUTY_W-1:0]         u;
   logic                      take;

   assign in_ready    = !valid_ff || out_ready;
   assign take        = in_valid && in_ready;
   assign out_valid   = valid_ff;
   assign duty_cycle  = duty_ff;
   assign heat_status = status_ff;

   // Sum the terms
   assign acc = {{(ACC_W-PTERM_W){in_data.p_term[PTERM_W-1]}}, in_data.p_term}
              + {{(ACC_W-ITERM_W){in_data.i_term[ITERM_W-1]}}, in_data.i_term}
              + {{(ACC_W-DTERM_W){in_data.d_term[DTERM_W-1]}}, in_data.d_term};
   assign whole = acc[ACC_W-1:FRAC_W];

   // Clamp to 0..100, then take the complement for duty; off words get zero duty
   always_comb begin
      if (acc[ACC_W-1] || acc == '0)
         u = '0;
      else if (whole > {{(ACC_W-FRAC_W-DUTY_W){1'b0}}, DUTY_FULL})
         u = DUTY_FULL;
      else
         u = whole[DUTY_W-1:0];
      duty_in = (in_data.status == ST_OFF) ? '0 : DUTY_FULL - u;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (in_ready)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         duty_ff   <= duty_in;
         status_ff <= in_data.status;
      end
   end

endmodule

FILE: sv/pid_heater_duty_control_unit.sv
// Channel   Dir  tdata (low bit up)                      tuser
// req_      in   measured_temp[7:0], target_temp[15:8]   system_on[0]
// rsp_      out  duty_cycle[6:0], zero[7]                heat_status[1:0]
// csr_      in   APB, signed gains at 0x0 prop (Q8.8), 0x4 integ (Q7.9), 0x8 deriv (Q9.7)
//
// One word may enter every cycle while req_tready is high; each word passes
// the input register, error stage, product stage and result register in turn.
// The error sum and previous error update as a word enters the error stage.
// A stalled rsp_ side fills the stage registers; req_tready drops only when
// every stage holds a word. Synchronous reset clears state and loads the
// default gains.
module pid_heater_duty_control_unit
   import pdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // measured_temp, target_temp
   input  logic [0:0]            req_tuser,   // system_on
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // duty_cycle, zero pad
   output logic [1:0]            rsp_tuser,   // heat_status
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   pdc_gains_type            gains;
   logic                     in_valid_ff;
   logic                     on_ff;
   logic signed [TEMP_W-1:0] meas_ff;
   logic signed [TEMP_W-1:0] targ_ff;
   logic                     err_ready;
   logic                     err_valid;
   pdc_err_type              err_data;
   logic                     prod_ready;
   logic                     prod_valid;
   pdc_prod_type             prod_data;
   logic                     out_ready_int;
   logic [DUTY_W-1:0]        duty;
   logic [STAT_W-1:0]        status;

   pdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   // Input register
   assign req_tready = !in_valid_ff || err_ready;

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_tready)
         in_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         on_ff   <= req_tuser[0];
         meas_ff <= req_tdata[7:0];
         targ_ff <= req_tdata[15:8];
      end
   end

   pdc_error u_error (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (in_valid_ff),
      .in_ready      (err_ready),
      .system_on     (on_ff),
      .measured_temp (meas_ff),
      .target_temp   (targ_ff),
      .out_valid     (err_valid),
      .out_ready     (prod_ready),
      .out_data      (err_data)
   );

   pdc_product u_product (
      .clock     (clock),
      .reset     (reset),
      .gains     (gains),
      .in_valid  (err_valid),
      .in_ready  (prod_ready),
      .in_data   (err_data),
      .out_valid (prod_valid),
      .out_ready (out_ready_int),
      .out_data  (prod_data)
   );

   pdc_output u_output (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (prod_valid),
      .in_ready    (out_ready_int),
      .in_data     (prod_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .duty_cycle  (duty),
      .heat_status (status)
   );

   assign rsp_tdata = {1'b0, duty};
   assign rsp_tuser = status;

`ifndef SYNTH
   // An off word always carries zero duty
   a_off_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_OFF) |-> (rsp_tdata == 8'd0))
      else $error("off word with nonzero duty");

   // Duty never exceeds full scale
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DUTY_W-1:0] <= DUTY_FULL && !rsp_tdata[7]))
      else $error("duty out of range");

   // No result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;
   import pdc_pkg::*;

   localparam logic [1:0] REG_UNMAPPED = 2'd3;
   localparam int         SUM_HI       = 8388607;
   localparam int         SUM_LO       = -8388608;
   localparam int         DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic [STAT_W-1:0] status;
   } heater_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;   // measured_temp[7:0], target_temp[15:8]
   logic [0:0]            req_tuser = '0;   // system_on[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // duty_cycle[6:0], zero[7]
   logic [1:0]            rsp_tuser;        // heat_status[1:0]
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Controller copy kept in step with the block
   logic signed [GAIN_W-1:0] gain_prop  = PROP_GAIN_RST;
   logic signed [GAIN_W-1:0] gain_integ = INTEG_GAIN_RST;
   logic signed [GAIN_W-1:0] gain_deriv = DERIV_GAIN_RST;
   int                       heat_err_sum = 0;
   int                       heat_prior_err = 0;

   heater_result_type expected_duty_q[$];
   int                mismatch_count = 0;
   bit                gaps_on = 1'b0;
   int                rsp_hold_len = 0;
   int                hold_left = 0;
   int                burst_left = 0;

   pid_heater_duty_control_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Advance the controller copy by one tick and return the duty word it gives
   function automatic heater_result_type predict_tick(bit on,
                                                      logic signed [TEMP_W-1:0] meas,
                                                      logic signed [TEMP_W-1:0] targ);
      heater_result_type r;
      int     e;
      int     s;
      longint acc;
      longint u;
      if (!on) begin
         heat_err_sum = 0;
         heat_prior_err = 0;
         r.duty = '0;
         r.status = ST_OFF;
         return r;
      end
      e = int'(targ) - int'(meas);
      s = heat_err_sum + e;
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      heat_err_sum = s;
      acc = 2 * longint'(gain_prop) * e + longint'(gain_integ) * heat_err_sum
            + 4 * longint'(gain_deriv) * (e - heat_prior_err);
      // clamp first, then truncate toward zero
      u = (acc <= 0) ? 0 : acc / 512;
      if (u > 100) u = 100;
      heat_prior_err = e;
      if (e > 2) r.status = ST_HEATING;
      else if (e < -2) r.status = ST_COOLING;
      else r.status = ST_STABLE;
      r.duty = DUTY_FULL - DUTY_W'(u);
      return r;
   endfunction

   // Offer one tick word, hold until taken, then queue its expected duty word
   task automatic send_tick(bit on, logic [TEMP_W-1:0] meas, logic [TEMP_W-1:0] targ);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {targ, meas};
      req_tuser  <= on;
      do @(posedge clock); while (!req_tready);
      expected_duty_q.push_back(predict_tick(on, meas, targ));
   endtask

   // Drop valid and wait for every expected word, then let the pipe settle
   task automatic wait_drain();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (expected_duty_q.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Read back all three gains against the copy
   task automatic check_gains();
      logic [31:0] rd;
      csr_access(1'b0, REG_PROP_GAIN, '0, rd);
      if (rd[15:0] !== gain_prop) report_mismatch("prop_gain", rd[15:0], gain_prop);
      csr_access(1'b0, REG_INTEG_GAIN, '0, rd);
      if (rd[15:0] !== gain_integ) report_mismatch("integ_gain", rd[15:0], gain_integ);
      csr_access(1'b0, REG_DERIV_GAIN, '0, rd);
      if (rd[15:0] !== gain_deriv) report_mismatch("deriv_gain", rd[15:0], gain_deriv);
   endtask

   // Write one register with random upper bits, which the block drops
   task automatic set_gain(logic [1:0] idx, int value);
      logic [31:0] rd;
      logic [15:0] upper;
      upper = 16'($urandom);
      csr_access(1'b1, idx, {upper, value[15:0]}, rd);
      case (idx)
         REG_PROP_GAIN:  gain_prop  = value[15:0];
         REG_INTEG_GAIN: gain_integ = value[15:0];
         REG_DERIV_GAIN: gain_deriv = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_gains(int kp, int ki, int kd);
      set_gain(REG_PROP_GAIN, kp);
      set_gain(REG_INTEG_GAIN, ki);
      set_gain(REG_DERIV_GAIN, kd);
      check_gains();
   endtask

   // Check each duty word against the oldest expectation
   always @(posedge clock) begin
      heater_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_duty_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = expected_duty_q.pop_front();
            if (rsp_tdata[6:0] !== want.duty) report_mismatch("duty_cycle", rsp_tdata[6:0], want.duty);
            if (rsp_tdata[7] !== 1'b0) report_mismatch("pad bit", rsp_tdata[7], 0);
            if (rsp_tuser !== want.status) report_mismatch("heat_status", rsp_tuser, want.status);
         end
      end
   end

   // Receiver: long hold on request, else random stall bursts
   always @(posedge clock) begin
      if (rsp_hold_len != 0) begin
         hold_left = rsp_hold_len;
         rsp_hold_len = 0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (burst_left > 0) begin
         rsp_tready <= 1'b0;
         burst_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         burst_left = $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Reset gains, band edges, both temperature extremes, off tick
   task automatic test_default_gains();
      send_tick(1'b1, 8'sd20, 8'sd20);
      send_tick(1'b1, -8'sd128, 8'sd127);
      send_tick(1'b1, 8'sd127, -8'sd128);
      send_tick(1'b1, 8'sd20, 8'sd22);
      send_tick(1'b1, 8'sd20, 8'sd23);
      send_tick(1'b1, 8'sd20, 8'sd18);
      send_tick(1'b1, 8'sd20, 8'sd17);
      send_tick(1'b0, 8'sd127, -8'sd128);
      wait_drain();
   endtask

   // Gain extremes of both signs, negative gains included
   task automatic test_gain_extremes();
      set_gains(32767, -32768, 32767);
      send_tick(1'b1, 8'sd0, 8'sd1);
      send_tick(1'b1, 8'sd10, -8'sd5);
      send_tick(1'b1, -8'sd128, 8'sd127);
      wait_drain();
      set_gains(-32768, 32767, -32768);
      send_tick(1'b1, 8'sd0, 8'sd1);
      send_tick(1'b1, 8'sd127, -8'sd128);
      send_tick(1'b1, 8'sd0, 8'sd0);
      wait_drain();
   endtask

   // A write past the last register changes nothing
   task automatic test_unmapped_register();
      set_gains(128, 16, -64);
      set_gain(REG_UNMAPPED, 16'h7fff);
      check_gains();
      send_tick(1'b1, 8'sd30, 8'sd40);
      send_tick(1'b1, 8'sd30, 8'sd50);
      wait_drain();
   endtask

   // Off tick clears sum and previous error but keeps the gains
   task automatic test_off_clears_state();
      set_gains(0, 256, 256);
      send_tick(1'b1, 8'sd0, 8'sd100);
      send_tick(1'b1, 8'sd0, 8'sd100);
      send_tick(1'b0, 8'sd0, 8'sd100);
      send_tick(1'b1, 8'sd0, 8'sd100);
      wait_drain();
      check_gains();
   endtask

   // Hold the receiver off long enough that the pipe fills and stalls input
   task automatic test_backpressure();
      set_gains(300, 20, 100);
      gaps_on = 1'b0;
      rsp_hold_len = 120;
      repeat (40) send_tick(1'b1, TEMP_W'($urandom), TEMP_W'($urandom));
      wait_drain();
   endtask

   // Wind the sum up, back down through zero and up again
   task automatic test_sum_windup();
      set_gains(0, 256, 0);
      gaps_on = 1'b0;
      send_tick(1'b0, 8'sd0, 8'sd0);
      repeat (100) send_tick(1'b1, -8'sd128, 8'sd127);
      repeat (200) send_tick(1'b1, 8'sd127, -8'sd128);
      repeat (100) send_tick(1'b1, -8'sd128, 8'sd127);
      wait_drain();
   endtask

   // Random gain sets, mostly running ticks near and far from the setpoint
   task automatic test_random_mix();
      logic [TEMP_W-1:0] meas;
      logic [TEMP_W-1:0] targ;
      int kp;
      int ki;
      int kd;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 3))
            0: begin
               kp = int'($urandom);
               ki = int'($urandom);
               kd = int'($urandom);
            end
            1: begin
               kp = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
               ki = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
               kd = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            end
            default: begin
               kp = int'($urandom_range(0, 1536)) - 512;
               ki = int'($urandom_range(0, 64)) - 32;
               kd = int'($urandom_range(0, 1024)) - 512;
            end
         endcase
         set_gains(kp, ki, kd);
         // no idling in the last part
         gaps_on = (phase < 6);
         repeat (200) begin
            meas = TEMP_W'($urandom);
            if ($urandom_range(0, 1) != 0) targ = TEMP_W'($urandom);
            else targ = meas + TEMP_W'(int'($urandom_range(0, 8)) - 4);
            send_tick($urandom_range(0, 24) != 0, meas, targ);
         end
         wait_drain();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_gains();
      gaps_on = 1'b1;
      test_default_gains();
      test_gain_extremes();
      test_unmapped_register();
      test_off_clears_state();
      test_backpressure();
      test_sum_windup();
      test_random_mix();
      wait_drain();
      if (expected_duty_q.size() != 0)
         report_mismatch("words never returned", 0, expected_duty_q.size());
      if (mismatch_count == 0) begin
         $display("[pid_heater_duty_control_unit] OK");
      end else begin
         $display("[pid_heater_duty_control_unit] ERROR");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("[pid_heater_duty_control_unit] ERROR");
      $finish;
   end

endmodule

FILE: pid_heater_duty_control_unit.f
sv/pdc_pkg.sv
sv/pdc_csr.sv
sv/pdc_error.sv
sv/pdc_product.sv
sv/pdc_output.sv
sv/pid_heater_duty_control_unit.sv
verif/tb_top.sv
